// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the SHA-1 block.
// Both expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off during reset, with a generic message.
`define SHA1MD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sha1md assertion failed");

// Clocked check, held off during reset, with a caller-supplied message.
`define SHA1MD_ASSERT_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`endif

// ===== hdl/sha1md_pkg.sv =====
package sha1md_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} sha1md_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
		logic        length_overflow;
	} sha1md_out_t;

	typedef enum logic [1:0] {
		JOB_BLOCK,
		JOB_FINAL,
		JOB_OVERFLOW
	} job_kind_t;

	typedef struct packed {
		job_kind_t    kind;
		logic [511:0] block;
	} job_t;

	typedef enum logic {
		FR_ACCEPT,
		FR_TAIL
	} front_state_t;

	typedef enum logic [1:0] {
		CR_IDLE,
		CR_ROUND,
		CR_ADD,
		CR_OUT
	} core_state_t;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [8:0]  PAD_LIMIT_BITS = 9'd440;
	localparam logic [6:0]  LAST_ROUND     = 7'd79;
	localparam logic [2:0]  LAST_WORD_IDX  = 3'd4;
	localparam logic [7:0]  PAD_BYTE       = 8'h80;

	localparam logic [31:0] K_0 = 32'h5A827999;
	localparam logic [31:0] K_1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_3 = 32'hCA62C1D6;

	function automatic logic [31:0] h_init(input logic [2:0] idx);
		logic [31:0] h;
		case (idx)
			3'd0:    h = 32'h67452301;
			3'd1:    h = 32'hEFCDAB89;
			3'd2:    h = 32'h98BADCFE;
			3'd3:    h = 32'h10325476;
			default: h = 32'hC3D2E1F0;
		endcase
		return h;
	endfunction

	// Place a byte big-endian at byte position pos of a 64-byte block.
	function automatic logic [511:0] put_byte(input logic [511:0] blk,
			input logic [5:0] pos, input logic [7:0] b);
		logic [511:0] r;
		r = blk;
		r[{~pos, 3'b000} +: 8] = b;
		return r;
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

endpackage

// ===== hdl/sha1md_front.sv =====
module sha1md_front import sha1md_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       msg_valid,
	output logic       msg_stall,
	input  sha1md_in_t msg,
	output logic       push,
	output job_t       push_job,
	input  logic       q_full
);

	front_state_t state_q, state_d;
	logic [511:0] buf_q, buf_d;
	logic [5:0]   pos_q, pos_d;
	logic [63:0]  len_q, len_d;
	logic         ovf_q, ovf_d;
	logic [63:0]  tail_len_q, tail_len_d;
	logic         tail_pad_q, tail_pad_d;

	logic         eff;
	logic [64:0]  sum;
	logic [63:0]  len_new;
	logic         ovf_new;
	logic [511:0] buf_ins, buf_pad;
	logic         full;
	logic [5:0]   pos_after;
	logic         take;

	assign msg_stall = (state_q != FR_ACCEPT) | q_full;
	assign take      = msg_valid & ~msg_stall;
	assign eff       = msg.has_byte & ~ovf_q;
	assign sum       = {1'b0, len_q} + 65'd8;
	assign len_new   = eff ? sum[63:0] : len_q;
	assign ovf_new   = ovf_q | (eff & sum[64]);
	assign buf_ins   = eff ? put_byte(buf_q, pos_q, msg.data_byte) : buf_q;
	assign full      = eff & (pos_q == 6'd63);
	assign pos_after = eff ? pos_q + 6'd1 : pos_q;
	assign buf_pad   = put_byte(buf_ins, pos_after, PAD_BYTE);

	always_comb begin
		state_d    = state_q;
		buf_d      = buf_q;
		pos_d      = pos_q;
		len_d      = len_q;
		ovf_d      = ovf_q;
		tail_len_d = tail_len_q;
		tail_pad_d = tail_pad_q;
		push       = 1'b0;
		push_job   = '{kind: JOB_BLOCK, block: buf_ins};
		case (state_q)
			FR_ACCEPT: begin
				if (take) begin
					if (msg.end_of_message) begin
						// close the message and drop back to reset values
						buf_d = '0;
						pos_d = '0;
						len_d = '0;
						ovf_d = 1'b0;
						push  = 1'b1;
						if (ovf_new) begin
							push_job = '{kind: JOB_OVERFLOW, block: '0};
						end else if (full) begin
							push_job   = '{kind: JOB_BLOCK, block: buf_ins};
							state_d    = FR_TAIL;
							tail_pad_d = 1'b1;
							tail_len_d = len_new;
						end else if ({pos_after, 3'b000} > PAD_LIMIT_BITS) begin
							push_job   = '{kind: JOB_BLOCK, block: buf_pad};
							state_d    = FR_TAIL;
							tail_pad_d = 1'b0;
							tail_len_d = len_new;
						end else begin
							push_job = '{kind: JOB_FINAL, block: {buf_pad[511:64], len_new}};
						end
					end else begin
						len_d = len_new;
						ovf_d = ovf_new;
						pos_d = pos_after;
						if (full) begin
							buf_d = '0;
							push  = ~ovf_new;
						end else begin
							buf_d = buf_ins;
						end
					end
				end
			end
			FR_TAIL: begin
				push_job = '{kind: JOB_FINAL,
					block: {(tail_pad_q ? PAD_BYTE : 8'h00), 440'b0, tail_len_q}};
				if (!q_full) begin
					push    = 1'b1;
					state_d = FR_ACCEPT;
				end
			end
			default: state_d = FR_ACCEPT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FR_ACCEPT;
			buf_q      <= '0;
			pos_q      <= '0;
			len_q      <= '0;
			ovf_q      <= 1'b0;
			tail_len_q <= '0;
			tail_pad_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			buf_q      <= buf_d;
			pos_q      <= pos_d;
			len_q      <= len_d;
			ovf_q      <= ovf_d;
			tail_len_q <= tail_len_d;
			tail_pad_q <= tail_pad_d;
		end
	end

endmodule

// ===== hdl/sha1md_queue.sv =====
`include "assert_macros.svh"

module sha1md_queue import sha1md_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	job_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	`SHA1MD_ASSERT(a_no_overfill, push |-> !full)
	`SHA1MD_ASSERT_MSG(a_no_underrun, pop |-> count_q != '0, "pop from empty queue")

endmodule

// ===== hdl/sha1md_core.sv =====
`include "assert_macros.svh"

module sha1md_core import sha1md_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	input  job_t        job,
	output logic        pop,
	output logic        dig_valid,
	input  logic        dig_stall,
	output sha1md_out_t dig
);

	core_state_t state_q, state_d;
	logic [31:0] chain_q [5];
	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [6:0]  round_q;
	logic        final_q;
	logic        ovf_out_q;
	logic [2:0]  idx_q;

	logic [31:0] f, k, temp, w_new, word_sel;

	always_comb begin
		if (round_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K_0;
		end else if (round_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K_1;
		end else if (round_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K_2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K_3;
		end
	end

	assign temp  = rotl(a_q, 5) + f + e_q + w_q[0] + k;
	assign w_new = rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);

	always_comb begin
		case (idx_q)
			3'd0:    word_sel = chain_q[0];
			3'd1:    word_sel = chain_q[1];
			3'd2:    word_sel = chain_q[2];
			3'd3:    word_sel = chain_q[3];
			default: word_sel = chain_q[4];
		endcase
	end

	assign dig_valid = (state_q == CR_OUT);
	always_comb begin
		if (ovf_out_q) begin
			dig = '{digest_word: '0, word_index: '0, last_word: 1'b1, length_overflow: 1'b1};
		end else begin
			dig = '{digest_word: word_sel, word_index: idx_q,
				last_word: (idx_q == LAST_WORD_IDX), length_overflow: 1'b0};
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		case (state_q)
			CR_IDLE: begin
				if (job_valid) begin
					pop     = 1'b1;
					state_d = (job.kind == JOB_OVERFLOW) ? CR_OUT : CR_ROUND;
				end
			end
			CR_ROUND: begin
				if (round_q == LAST_ROUND) begin
					state_d = CR_ADD;
				end
			end
			CR_ADD: state_d = final_q ? CR_OUT : CR_IDLE;
			CR_OUT: begin
				if (!dig_stall && (ovf_out_q || idx_q == LAST_WORD_IDX)) begin
					state_d = CR_IDLE;
				end
			end
			default: state_d = CR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) begin
				chain_q[i] <= h_init(3'(i));
			end
			round_q   <= '0;
			final_q   <= 1'b0;
			ovf_out_q <= 1'b0;
			idx_q     <= '0;
		end else begin
			case (state_q)
				CR_IDLE: begin
					if (job_valid) begin
						ovf_out_q <= (job.kind == JOB_OVERFLOW);
						final_q   <= (job.kind == JOB_FINAL);
						idx_q     <= '0;
						round_q   <= '0;
					end
				end
				CR_ROUND: round_q <= round_q + 7'd1;
				CR_ADD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					chain_q[4] <= chain_q[4] + e_q;
					ovf_out_q  <= 1'b0;
					idx_q      <= '0;
				end
				CR_OUT: begin
					if (!dig_stall) begin
						if (ovf_out_q || idx_q == LAST_WORD_IDX) begin
							for (int i = 0; i < 5; i++) begin
								chain_q[i] <= h_init(3'(i));
							end
							ovf_out_q <= 1'b0;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// working variables and message schedule window
	always_ff @(posedge clk) begin
		if (state_q == CR_IDLE && job_valid) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= job.block[511 - 32*i -: 32];
			end
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (state_q == CR_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
			e_q <= d_q;
			d_q <= c_q;
			c_q <= rotl(b_q, 30);
			b_q <= a_q;
			a_q <= temp;
		end
	end

	`SHA1MD_ASSERT(a_round_bound, state_q == CR_ROUND |-> round_q <= LAST_ROUND)
	`SHA1MD_ASSERT_MSG(a_out_hold, dig_valid && dig_stall |=> $stable(idx_q) && dig_valid,
		"digest word moved while stalled")
	`SHA1MD_ASSERT(a_pop_idle, pop |-> state_q == CR_IDLE && job_valid)

endmodule

// ===== hdl/sha1_message_digest.sv =====
// SHA-1 digest over a byte stream.
// Input channel msg (msg_valid / msg_stall): each transfer carries at most one
// byte (has_byte) and may mark the end of the message (end_of_message). An
// item with neither has no effect.
// Output channel dig (dig_valid / dig_stall): after the end mark, five
// transfers give h0..h4 with word_index 0..4, last_word on the fifth. A
// message longer than 2^64 - 1 bits gives a single transfer with
// length_overflow set instead.
// Front: packs bytes and pads, one item per cycle, and pushes whole 64-byte
// blocks into a two-entry block queue; it stalls while that queue is full and
// while it pushes a second padding block when the end needs one.
// Back: one SHA-1 round per cycle; each block takes a load step, 80 rounds
// and an add step, so the sustained input rate is set by the round engine.
// With the engine idle, the first digest word is offered once the last block
// (the extra padding block, when one is needed) has had its rounds and add.
// The input keeps accepting into the queue while digest words wait on a
// stalled receiver; the digest payload holds steady while stalled.
// Reset clears buffer, length and chain value to the initial hash at once.
module sha1_message_digest import sha1md_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_stall,
	input  sha1md_in_t  msg,
	output logic        dig_valid,
	input  logic        dig_stall,
	output sha1md_out_t dig
);

	logic push, q_full, pop, head_valid;
	job_t push_job, head_job;

	// byte packing, padding and length count
	sha1md_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg),
		.push      (push),
		.push_job  (push_job),
		.q_full    (q_full)
	);

	// decouple the front from the round engine
	sha1md_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// compression rounds, chain value and digest output
	sha1md_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (head_valid),
		.job       (head_job),
		.pop       (pop),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.dig       (dig)
	);

endmodule
